// ===== rtl/core/heater_thermostat_with_safety_cutoffs_defines.svh =====
// Assertion macros shared by the thermostat RTL.
`ifndef HEATER_THERMOSTAT_WITH_SAFETY_CUTOFFS_DEFINES_SVH
`define HEATER_THERMOSTAT_WITH_SAFETY_CUTOFFS_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge of clk_i, silenced while rst_ni is low.
`define HTSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be seen on a rising edge of clk_i.
`define HTSC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define HTSC_ASSERT(lbl, prop, msg)
`define HTSC_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/htsc_pkg.sv =====
// Types and constants shared by the thermostat core.
`default_nettype none

package htsc_pkg;

  localparam int unsigned TempW    = 12;
  localparam int unsigned TargetW  = 11;
  localparam int unsigned HystW    = 8;
  localparam int unsigned SessionW = 22;
  localparam int unsigned ConvW    = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 22;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_TARGET_TEMP  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HYSTERESIS   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_TEMP     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SESSION_LIM  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_READ_INTVL   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CONV_WAIT    = 3'd5;

  // Configuration values after reset.
  localparam logic [TargetW-1:0]  RST_TARGET_TEMP = 11'd1120;
  localparam logic [HystW-1:0]    RST_HYSTERESIS  = 8'd32;
  localparam logic [TargetW-1:0]  RST_MAX_TEMP    = 11'd1760;
  localparam logic [SessionW-1:0] RST_SESSION_LIM = 22'd3600000;
  localparam logic [ConvW-1:0]    RST_READ_INTVL  = 16'd2000;
  localparam logic [ConvW-1:0]    RST_CONV_WAIT   = 16'd750;

  localparam logic signed [TempW-1:0] RST_LAST_TEMP  = 12'sd320;
  // A reading at or below this value means the probe is disconnected.
  localparam logic signed [TempW-1:0] SENTINEL_LIMIT = -12'sd2032;

  localparam logic [SessionW-1:0] SESSION_MAX = {SessionW{1'b1}};
  localparam logic [ConvW-1:0]    CONV_MAX    = {ConvW{1'b1}};

  // Item kinds carried on the input tuser bit.
  localparam logic REQ_TICK    = 1'b0;
  localparam logic REQ_COMMAND = 1'b1;

  localparam logic MODE_OFF  = 1'b0;
  localparam logic MODE_HEAT = 1'b1;

  typedef enum logic [1:0] {
    CAUSE_NONE     = 2'd0,
    CAUSE_SESSION  = 2'd1,
    CAUSE_FAULT    = 2'd2,
    CAUSE_OVERTEMP = 2'd3
  } cause_e;

  typedef struct packed {
    logic [TargetW-1:0]  target_temp;
    logic [HystW-1:0]    hysteresis_band;
    logic [TargetW-1:0]  max_temp;
    logic [SessionW-1:0] session_limit_ms;
    logic [ConvW-1:0]    read_interval_ms;
    logic [ConvW-1:0]    settle_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic                    heater_active;
    logic                    heat_mode;
    logic                    fault_flag;
    logic                    conversion_pending;
    logic [SessionW-1:0]     session_timer;
    logic [ConvW-1:0]        conversion_timer;
    logic signed [TempW-1:0] last_temp;
  } state_t;

  typedef struct packed {
    logic                    heater_on;
    logic                    heat_mode;
    logic                    sensor_fault;
    logic                    start_conversion;
    logic                    sample_used;
    logic signed [TempW-1:0] current_temp;
    logic                    command_rejected;
    cause_e                  shutdown_cause;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/heater_thermostat_with_safety_cutoffs.sv =====
// Top level of the heater thermostat with hysteresis and safety cutoffs.
//
//   Channel   Direction  Ports                          Payload
//   s_*       in         s_tvalid_i/s_tready_o          tuser: req_type
//                        s_tdata_i[15:0], s_tuser_i     tdata: mode_request, sensor_temp
//   m_*       out        m_tvalid_o/m_tready_i          tdata: status of the block after
//                        m_tdata_o[23:0]                the beat, one result per input beat
//   cfg_*     in         cfg_we_i, cfg_idx_i,           six registers, write only
//                        cfg_data_i[21:0]
//
// Every input beat is worked out combinationally: the step logic sits between the
// state registers and a two-entry output buffer, so one beat can be accepted per cycle while
// s_tready_o is high, and its result is registered in the output or the skid register.
// The buffer is an output register backed by one skid register; s_tready_o is low only
// while the skid register is full, which happens when the master side stalls.
// Reset (rst_ni low, asynchronous) clears the thermostat state, empties the buffer and
// loads the documented default values into the configuration registers.

`default_nettype none
`include "heater_thermostat_with_safety_cutoffs_defines.svh"

module heater_thermostat_with_safety_cutoffs import htsc_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,

  input  wire logic                s_tvalid_i,
  output logic                     s_tready_o,
  // [0] mode_request, [12:1] sensor_temp, [15:13] zero
  input  wire logic [15:0]         s_tdata_i,
  // [0] req_type
  input  wire logic                s_tuser_i,

  output logic                     m_tvalid_o,
  input  wire logic                m_tready_i,
  // [0] heater_on, [1] heat_mode, [2] sensor_fault, [3] start_conversion,
  // [4] sample_used, [16:5] current_temp, [17] command_rejected,
  // [19:18] shutdown_cause, [23:20] zero
  output logic [23:0]              m_tdata_o,

  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  result_t result_d;
  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    push;
  logic    pop;

  // Configuration writes land directly in their register; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_temp        <= RST_TARGET_TEMP;
      cfg_q.hysteresis_band    <= RST_HYSTERESIS;
      cfg_q.max_temp           <= RST_MAX_TEMP;
      cfg_q.session_limit_ms   <= RST_SESSION_LIM;
      cfg_q.read_interval_ms   <= RST_READ_INTVL;
      cfg_q.settle_delay_ms    <= RST_CONV_WAIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARGET_TEMP: cfg_q.target_temp        <= cfg_data_i[TargetW-1:0];
        CFG_HYSTERESIS:  cfg_q.hysteresis_band    <= cfg_data_i[HystW-1:0];
        CFG_MAX_TEMP:    cfg_q.max_temp           <= cfg_data_i[TargetW-1:0];
        CFG_SESSION_LIM: cfg_q.session_limit_ms   <= cfg_data_i[SessionW-1:0];
        CFG_READ_INTVL:  cfg_q.read_interval_ms   <= cfg_data_i[ConvW-1:0];
        CFG_CONV_WAIT:   cfg_q.settle_delay_ms    <= cfg_data_i[ConvW-1:0];
        default: ;
      endcase
    end
  end

  // The step logic works on the current state and the beat on the slave side.
  htsc_step u_step (
    .cfg_i          (cfg_q),
    .state_i        (state_q),
    .req_type_i     (s_tuser_i),
    .mode_request_i (s_tdata_i[0]),
    .sensor_temp_i  ($signed(s_tdata_i[12:1])),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  assign s_tready_o = !skid_valid_q;
  assign push       = s_tvalid_i && s_tready_o;
  assign pop        = out_valid_q && m_tready_i;

  // The thermostat state moves on only when a beat is accepted.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.heater_active      <= 1'b0;
      state_q.heat_mode          <= 1'b0;
      state_q.fault_flag         <= 1'b0;
      state_q.conversion_pending <= 1'b0;
      state_q.session_timer      <= '0;
      state_q.conversion_timer   <= '0;
      state_q.last_temp          <= RST_LAST_TEMP;
    end else if (push) begin
      state_q <= state_d;
    end
  end

  // Output register with a skid register behind it. When the output register frees up it
  // takes the skid entry first, so results leave in the order they were made.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= result_d;
      end
    end else if (push) begin
      skid_q <= result_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'b0000,
                       out_q.shutdown_cause,
                       out_q.command_rejected,
                       out_q.current_temp,
                       out_q.sample_used,
                       out_q.start_conversion,
                       out_q.sensor_fault,
                       out_q.heat_mode,
                       out_q.heater_on};

  // The heater is only ever driven while heat mode is selected.
  `HTSC_ASSERT_NEVER(a_heater_needs_mode, state_q.heater_active && !state_q.heat_mode,
                     "heater on outside heat mode")
  // A sensor fault and an energised heater exclude each other.
  `HTSC_ASSERT_NEVER(a_no_heat_on_fault, state_q.heater_active && state_q.fault_flag,
                     "heater on during sensor fault")
  // The skid register is only filled behind a full output register.
  `HTSC_ASSERT_NEVER(a_skid_order, skid_valid_q && !out_valid_q,
                     "skid entry without output entry")
  // A beat never both starts a conversion and consumes its sample.
  `HTSC_ASSERT_NEVER(a_start_or_use, push && result_d.start_conversion && result_d.sample_used,
                     "start and use on the same beat")
  // A stalled result stays in place.
  `HTSC_ASSERT(a_hold_on_stall, out_valid_q && !m_tready_i |=> out_valid_q && $stable(out_q),
               "result changed while stalled")

endmodule

`default_nettype wire

// ===== rtl/core/htsc_step.sv =====
// Next-state and result logic for one tick or one mode command.
`default_nettype none

module htsc_step import htsc_pkg::*; (
  input  cfg_t                    cfg_i,
  input  state_t                  state_i,
  input  logic                    req_type_i,
  input  logic                    mode_request_i,
  input  logic signed [TempW-1:0] sensor_temp_i,
  output state_t                  state_o,
  output result_t                 result_o
);

  state_t                  nx;
  logic                    start;
  logic                    used;
  logic                    rejected;
  cause_e                  cause;
  logic signed [TempW:0]   temp_x;
  logic signed [TempW:0]   max_x;
  logic signed [TempW:0]   target_x;
  logic signed [TempW:0]   low_x;

  assign temp_x   = {sensor_temp_i[TempW-1], sensor_temp_i};
  assign max_x    = $signed({2'b00, cfg_i.max_temp});
  assign target_x = $signed({2'b00, cfg_i.target_temp});
  assign low_x    = target_x - $signed({5'b00000, cfg_i.hysteresis_band});

  always_comb begin
    nx       = state_i;
    start    = 1'b0;
    used     = 1'b0;
    rejected = 1'b0;
    cause    = CAUSE_NONE;

    if (req_type_i == REQ_COMMAND) begin
      if (mode_request_i == MODE_HEAT) begin
        if (state_i.fault_flag) begin
          rejected = 1'b1;
        end else begin
          nx.heat_mode = 1'b1;
        end
      end else begin
        nx.heater_active = 1'b0;
        nx.heat_mode     = 1'b0;
      end
    end else begin
      // Session limit is checked before the sample, so a fault or overtemperature in a used sample wins the cause.
      if (nx.heater_active) begin
        if (nx.session_timer != SESSION_MAX) begin
          nx.session_timer = nx.session_timer + 1'b1;
        end
        if (nx.session_timer >= cfg_i.session_limit_ms) begin
          nx.heater_active = 1'b0;
          nx.heat_mode     = 1'b0;
          cause            = CAUSE_SESSION;
        end
      end

      if (nx.conversion_timer != CONV_MAX) begin
        nx.conversion_timer = nx.conversion_timer + 1'b1;
      end

      if (!nx.conversion_pending) begin
        if (nx.conversion_timer >= cfg_i.read_interval_ms) begin
          start                 = 1'b1;
          nx.conversion_pending = 1'b1;
          nx.conversion_timer   = '0;
        end
      end else if (nx.conversion_timer >= cfg_i.settle_delay_ms) begin
        nx.conversion_pending = 1'b0;
        used                  = 1'b1;
        if (sensor_temp_i <= SENTINEL_LIMIT) begin
          nx.heater_active = 1'b0;
          nx.heat_mode     = 1'b0;
          nx.fault_flag    = 1'b1;
          cause            = CAUSE_FAULT;
        end else begin
          nx.fault_flag = 1'b0;
          nx.last_temp  = sensor_temp_i;
          if (temp_x >= max_x) begin
            nx.heater_active = 1'b0;
            nx.heat_mode     = 1'b0;
            cause            = CAUSE_OVERTEMP;
          end else if (nx.heat_mode) begin
            if (!nx.heater_active && (temp_x < low_x)) begin
              nx.heater_active = 1'b1;
              nx.session_timer = '0;
            end else if (nx.heater_active && (temp_x >= target_x)) begin
              nx.heater_active = 1'b0;
            end
          end
        end
      end
    end
  end

  assign state_o = nx;

  assign result_o.heater_on        = nx.heater_active;
  assign result_o.heat_mode        = nx.heat_mode;
  assign result_o.sensor_fault     = nx.fault_flag;
  assign result_o.start_conversion = start;
  assign result_o.sample_used      = used;
  assign result_o.current_temp     = nx.last_temp;
  assign result_o.command_rejected = rejected;
  assign result_o.shutdown_cause   = cause;

endmodule

`default_nettype wire
